// ===== hw/rtl/brpc_pkg.sv =====
// Shared constants, codes and types for the byte ring buffer with peek/commit reads.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package brpc_pkg;

    localparam int BUFFER_SIZE = 128;
    localparam int PTR_W       = $clog2(BUFFER_SIZE);
    localparam int DATA_W      = 8;
    localparam int LEN_W       = 7;
    localparam int PEEK_LIMIT  = 64;
    // compare width wide enough for both a pointer difference and a length field
    localparam int CMP_W       = (PTR_W > LEN_W) ? PTR_W : LEN_W;

    localparam logic [DATA_W-1:0] OVERRUN_MARK = 8'h00;

    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_PEEK   = 2'd1,
        OP_COMMIT = 2'd2
    } t_op;

    typedef struct packed {
        logic [DATA_W-1:0] data_out;
        logic              byte_valid;
        logic              last;
        logic [LEN_W-1:0]  fill_level;
        logic              overrun;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/brpc_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module brpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/byte_ring_buffer_peek_commit_core.sv =====
// Top level of the byte ring buffer with peek/commit reads.
// Depends on brpc_pkg and brpc_ram.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one command beat: put a byte,
//   peek up to max_len bytes from the tail, or commit (release) bytes at the tail.
//   Output channel (o_out_valid / i_out_stall) returns result beats. Put, commit
//   and the unused code give one beat; a peek gives one beat per byte read
//   (the final one with o_last set), or one non-valid beat if nothing is readable.
//   Every beat carries the fill level after the command.
// Operation:
//   A result beat passes the RAM read register (or the result register beside it
//   for beats without RAM data), then the output register, or the skid entry
//   while the output is held. Put and commit leave the input free for the next
//   command while the output has room. A peek makes one RAM read per cycle through
//   the single read port while the output has room; the input is stalled until
//   the peek's last read is issued. The bytes live in one synchronous RAM; the
//   pointers are registers.
// Reset:
//   Synchronous, active low. Pointers go to zero, the buffer is empty, pending
//   results are dropped. RAM contents are not cleared.
// Stall:
//   An output register plus one skid entry hold results; reads are issued only
//   when a slot is guaranteed, so a stalled output back-pressures the input
//   (and a running peek) without losing or duplicating beats.
`timescale 1ns / 1ps
`default_nettype none

module byte_ring_buffer_peek_commit_core
    import brpc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_operation,
    input  wire logic [DATA_W-1:0] i_data_in,
    input  wire logic [LEN_W-1:0]  i_max_len,
    input  wire logic [LEN_W-1:0]  i_commit_len,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [DATA_W-1:0]      o_data_out,
    output logic                   o_byte_valid,
    output logic                   o_last,
    output logic [LEN_W-1:0]       o_fill_level,
    output logic                   o_overrun
);

    typedef enum logic {
        ST_IDLE,
        ST_PEEK
    } t_state;

    t_state           r_state, n_state;
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [PTR_W-1:0] r_rd_addr, n_rd_addr;
    logic [LEN_W-1:0] r_cnt, n_cnt;

    // result in flight toward the output stage (RAM read or direct result)
    logic             r_q_vld, n_q_vld;
    logic             r_q_ram, n_q_ram;
    t_result          r_q_res, n_q_res;

    logic             r_out_valid, n_out_valid;
    t_result          r_out, n_out;
    logic             r_pend_valid, n_pend_valid;
    t_result          r_pend, n_pend;

    logic [DATA_W-1:0] rd_data;
    logic              wr_en;
    logic [PTR_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [PTR_W-1:0]  rd_addr;

    logic             take;
    logic [1:0]       occ;
    logic             space;
    logic             in_accept;
    logic [PTR_W-1:0] fill;
    logic [PTR_W-1:0] wp_inc;
    logic             full;
    logic [LEN_W-1:0] lim;
    logic [CMP_W-1:0] fill_c;
    logic [CMP_W-1:0] peek_c;
    logic [CMP_W-1:0] clen_c;
    logic [LEN_W-1:0] peek_n;
    logic [PTR_W-1:0] rp_commit;
    t_result          arr;

    brpc_ram #(
        .WIDTH(DATA_W),
        .DEPTH(BUFFER_SIZE)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    always_comb begin
        take  = r_out_valid && !i_out_stall;
        occ   = {1'b0, r_out_valid} + {1'b0, r_pend_valid} + {1'b0, r_q_vld} - {1'b0, take};
        space = (occ < 2'd2);

        in_accept  = (r_state == ST_IDLE) && i_in_valid && space;
        o_in_stall = !((r_state == ST_IDLE) && space);

        fill   = r_wp - r_rp;
        wp_inc = r_wp + PTR_W'(1);
        full   = (wp_inc == r_rp);
        fill_c = CMP_W'(fill);

        lim    = (i_max_len > LEN_W'(PEEK_LIMIT)) ? LEN_W'(PEEK_LIMIT) : i_max_len;
        peek_c = (CMP_W'(lim) < fill_c) ? CMP_W'(lim) : fill_c;
        peek_n = LEN_W'(peek_c);

        clen_c    = (CMP_W'(i_commit_len) < fill_c) ? CMP_W'(i_commit_len) : fill_c;
        rp_commit = r_rp + PTR_W'(clen_c);

        arr = r_q_res;
        if (r_q_ram) begin
            arr.data_out = rd_data;
        end

        n_state   = r_state;
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_rd_addr = r_rd_addr;
        n_cnt     = r_cnt;
        n_q_vld   = 1'b0;
        n_q_ram   = 1'b0;
        n_q_res   = '0;
        n_q_res.last       = 1'b1;
        n_q_res.fill_level = LEN_W'(fill);

        wr_en   = 1'b0;
        wr_addr = r_wp;
        wr_data = i_data_in;
        rd_en   = 1'b0;
        rd_addr = r_rd_addr;

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_q_vld = 1'b1;
                    case (t_op'(i_operation))
                        OP_PUT: begin
                            wr_en = 1'b1;
                            if (full) begin
                                // overrun: mark the newest byte, pointers hold
                                wr_addr = r_wp - PTR_W'(1);
                                wr_data = OVERRUN_MARK;
                                n_q_res.overrun = 1'b1;
                            end else begin
                                n_wp = wp_inc;
                                n_q_res.fill_level = LEN_W'(wp_inc - r_rp);
                            end
                        end
                        OP_PEEK: begin
                            if (peek_n != '0) begin
                                rd_en   = 1'b1;
                                rd_addr = r_rp;
                                n_q_ram = 1'b1;
                                n_q_res.byte_valid = 1'b1;
                                n_q_res.last       = (peek_n == LEN_W'(1));
                                if (peek_n != LEN_W'(1)) begin
                                    n_state   = ST_PEEK;
                                    n_cnt     = peek_n - LEN_W'(1);
                                    n_rd_addr = r_rp + PTR_W'(1);
                                end
                            end
                        end
                        OP_COMMIT: begin
                            n_rp = rp_commit;
                            n_q_res.fill_level = LEN_W'(r_wp - rp_commit);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PEEK: begin
                if (space) begin
                    rd_en   = 1'b1;
                    n_q_vld = 1'b1;
                    n_q_ram = 1'b1;
                    n_q_res.byte_valid = 1'b1;
                    n_q_res.last       = (r_cnt == LEN_W'(1));
                    n_cnt     = r_cnt - LEN_W'(1);
                    n_rd_addr = r_rd_addr + PTR_W'(1);
                    if (r_cnt == LEN_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // output register and skid entry; skid is always older than the arriving beat
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        if (!r_out_valid || take) begin
            if (r_pend_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_pend;
                n_pend_valid = r_q_vld;
                n_pend       = arr;
            end else begin
                n_out_valid = r_q_vld;
                n_out       = arr;
            end
        end else if (r_q_vld) begin
            n_pend_valid = 1'b1;
            n_pend       = arr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_wp         <= '0;
            r_rp         <= '0;
            r_q_vld      <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_wp         <= n_wp;
            r_rp         <= n_rp;
            r_q_vld      <= n_q_vld;
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
        r_rd_addr <= n_rd_addr;
        r_cnt     <= n_cnt;
        r_q_ram   <= n_q_ram;
        r_q_res   <= n_q_res;
        r_out     <= n_out;
        r_pend    <= n_pend;
    end

    assign o_out_valid  = r_out_valid;
    assign o_data_out   = r_out.data_out;
    assign o_byte_valid = r_out.byte_valid;
    assign o_last       = r_out.last;
    assign o_fill_level = r_out.fill_level;
    assign o_overrun    = r_out.overrun;

    // skid entry is only used behind a held output beat
    a_pend_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_out_valid)
        else $error("skid entry valid without output beat");

    // an arriving beat always finds a free slot
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_q_vld && r_out_valid && !take) |-> !r_pend_valid)
        else $error("result beat arrived with no free slot");

    // pointers do not move while a peek is being read out
    a_peek_ptrs_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PEEK) |=> ($stable(r_wp) && $stable(r_rp)))
        else $error("pointer moved during peek");

    // overrun beats never carry data and always close their command
    a_overrun_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overrun) |-> (!o_byte_valid && o_last))
        else $error("malformed overrun beat");

endmodule

`default_nettype wire

// ===== sim/tb_byte_ring_buffer_peek_commit_core.sv =====
// Testbench for byte_ring_buffer_peek_commit_core: random and directed put, peek and commit
// traffic under varied handshake idling, checked beat by beat against an in-bench ring model.
// Depends on brpc_pkg and the RTL of the core.
`timescale 1ns / 1ps

module tb_byte_ring_buffer_peek_commit_core;
    import brpc_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         HOLD_CYCLES = 300;
    localparam int         DRAIN_CYCLES = 20;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_in_valid   = 1'b0;
    logic [1:0]        i_operation  = OP_PUT;
    logic [DATA_W-1:0] i_data_in    = '0;
    logic [LEN_W-1:0]  i_max_len    = '0;
    logic [LEN_W-1:0]  i_commit_len = '0;
    logic              i_out_stall  = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [DATA_W-1:0] o_data_out;
    logic              o_byte_valid;
    logic              o_last;
    logic [LEN_W-1:0]  o_fill_level;
    logic              o_overrun;

    byte_ring_buffer_peek_commit_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_data_in    (i_data_in),
        .i_max_len    (i_max_len),
        .i_commit_len (i_commit_len),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_data_out   (o_data_out),
        .o_byte_valid (o_byte_valid),
        .o_last       (o_last),
        .o_fill_level (o_fill_level),
        .o_overrun    (o_overrun)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ring model state
    logic [DATA_W-1:0] ring_mem [0:BUFFER_SIZE-1];
    logic [PTR_W-1:0]  head_ptr = '0;
    logic [PTR_W-1:0]  tail_ptr = '0;
    t_result           pending_beats [$];

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    bit hold_go      = 1'b0;
    int hold_left    = 0;

    int n_put = 0, n_peek = 0, n_commit = 0, n_unused = 0, n_overrun = 0;
    int n_beats = 0, n_err = 0, cycle_cnt = 0;

    // Advance the ring model by one command and queue the beats it should produce.
    task automatic ring_apply(input logic [1:0] op, input logic [DATA_W-1:0] data,
                              input logic [LEN_W-1:0] maxl, input logic [LEN_W-1:0] clen);
        t_result          beat;
        logic [PTR_W-1:0] fill;
        int               n;
        int               lim;
        fill = head_ptr - tail_ptr;
        beat = '{data_out: '0, byte_valid: 1'b0, last: 1'b1, fill_level: '0, overrun: 1'b0};
        case (op)
            OP_PUT: begin
                n_put++;
                if (PTR_W'(head_ptr + 1'b1) != tail_ptr) begin
                    ring_mem[head_ptr] = data;
                    head_ptr = head_ptr + 1'b1;
                end else begin
                    // full: the newest byte becomes the overrun mark
                    ring_mem[PTR_W'(head_ptr - 1'b1)] = OVERRUN_MARK;
                    beat.overrun = 1'b1;
                    n_overrun++;
                end
            end
            OP_PEEK: begin
                n_peek++;
                lim = (maxl > PEEK_LIMIT) ? PEEK_LIMIT : int'(maxl);
                n   = (int'(fill) > lim) ? lim : int'(fill);
                for (int i = 0; i < n; i++) begin
                    beat.data_out   = ring_mem[PTR_W'(tail_ptr + i)];
                    beat.byte_valid = 1'b1;
                    beat.last       = (i == n - 1);
                    beat.fill_level = LEN_W'(fill);
                    pending_beats.push_back(beat);
                end
                if (n > 0) return;
            end
            OP_COMMIT: begin
                n_commit++;
                tail_ptr = tail_ptr + ((clen > fill) ? fill : PTR_W'(clen));
            end
            default: n_unused++;
        endcase
        beat.fill_level = LEN_W'(PTR_W'(head_ptr - tail_ptr));
        pending_beats.push_back(beat);
    endtask

    task automatic send_cmd(input logic [1:0] op, input logic [DATA_W-1:0] data,
                            input logic [LEN_W-1:0] maxl, input logic [LEN_W-1:0] clen);
        while ($urandom_range(99) < snd_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_data_in    <= data;
        i_max_len    <= maxl;
        i_commit_len <= clen;
        do @(posedge i_clk); while (o_in_stall);
        ring_apply(op, data, maxl, clen);
    endtask

    // Output stall: random per idle pattern, or a long hold-off once requested.
    always @(negedge i_clk) begin
        if (hold_go) begin
            hold_left = HOLD_CYCLES;
            hold_go   = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            n_err++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_beats++;
            if (pending_beats.size() == 0) begin
                n_err++;
                $display("%0t: unexpected beat, expected none, got data %0h valid %0b last %0b",
                         $time, o_data_out, o_byte_valid, o_last);
            end else begin
                want = pending_beats.pop_front();
                check_field("data_out",   want.data_out,       o_data_out);
                check_field("byte_valid", 8'(want.byte_valid), 8'(o_byte_valid));
                check_field("last",       8'(want.last),       8'(o_last));
                check_field("fill_level", 8'(want.fill_level), 8'(o_fill_level));
                check_field("overrun",    8'(want.overrun),    8'(o_overrun));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d beats outstanding", $time, pending_beats.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic test_directed;
        send_cmd(OP_PEEK,   8'h00, 7'd5,   7'd0);     // peek on empty buffer
        send_cmd(OP_COMMIT, 8'h00, 7'd0,   7'd3);     // commit on empty, clamps to zero
        send_cmd(OP_PUT,    8'h00, 7'd0,   7'd0);
        send_cmd(OP_PUT,    8'hFF, 7'd127, 7'd127);
        send_cmd(OP_PUT,    8'h55, 7'd0,   7'd0);
        send_cmd(OP_PUT,    8'hAA, 7'd0,   7'd0);
        send_cmd(OP_UNUSED, 8'hFF, 7'd127, 7'd127);   // unused code leaves state alone
        send_cmd(OP_PEEK,   8'hFF, 7'd0,   7'd127);   // zero-length peek
        send_cmd(OP_PEEK,   8'h00, 7'd1,   7'd0);
        send_cmd(OP_PEEK,   8'h00, 7'd64,  7'd0);
        send_cmd(OP_PEEK,   8'h00, 7'd127, 7'd0);     // above the peek limit
        send_cmd(OP_COMMIT, 8'h00, 7'd0,   7'd0);
        send_cmd(OP_COMMIT, 8'h00, 7'd0,   7'd1);
        send_cmd(OP_PEEK,   8'h00, 7'd64,  7'd0);
        send_cmd(OP_COMMIT, 8'h00, 7'd0,   7'd127);   // beyond fill, clamps
        send_cmd(OP_PEEK,   8'h00, 7'd64,  7'd0);
    endtask

    task automatic test_random_traffic(input int count);
        int                r;
        logic [LEN_W-1:0]  maxl;
        logic [LEN_W-1:0]  clen;
        for (int k = 0; k < count; k++) begin
            r    = $urandom_range(99);
            maxl = ($urandom_range(99) < 85) ? LEN_W'($urandom_range(PEEK_LIMIT))
                                             : LEN_W'($urandom_range(127, PEEK_LIMIT + 1));
            clen = ($urandom_range(99) < 70) ? LEN_W'($urandom_range(8))
                                             : LEN_W'($urandom_range(127));
            if (r < 50)
                send_cmd(OP_PUT, DATA_W'($urandom), maxl, clen);
            else if (r < 78)
                send_cmd(OP_PEEK, DATA_W'($urandom), maxl, clen);
            else if (r < 97)
                send_cmd(OP_COMMIT, DATA_W'($urandom), maxl, clen);
            else
                send_cmd(OP_UNUSED, DATA_W'($urandom), maxl, clen);
        end
    endtask

    // Output held off first so the core backs up, then the buffer is filled past full.
    task automatic test_fill_overrun;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        hold_go = 1'b1;
        send_cmd(OP_COMMIT, DATA_W'($urandom), LEN_W'($urandom), 7'd127);
        for (int k = 0; k < BUFFER_SIZE + 5; k++)
            send_cmd(OP_PUT, DATA_W'($urandom), LEN_W'($urandom), LEN_W'($urandom));
        send_cmd(OP_PEEK,   8'h00, 7'd64,  7'd0);
        send_cmd(OP_PEEK,   8'h00, 7'd127, 7'd0);
        send_cmd(OP_COMMIT, 8'h00, 7'd0,   7'd100);
        send_cmd(OP_PEEK,   8'h00, 7'd64,  7'd0);
        send_cmd(OP_COMMIT, 8'h00, 7'd0,   7'd127);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        snd_idle_pct = 37;
        rcv_idle_pct = 78;
        test_directed();
        test_random_traffic(40);

        snd_idle_pct = 78;
        rcv_idle_pct = 37;
        test_random_traffic(40);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_fill_overrun();
        test_random_traffic(40);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d puts (%0d overruns), %0d peeks, %0d commits, %0d unused codes",
                 n_put, n_overrun, n_peek, n_commit, n_unused);
        $display("Checked %0d result beats across three idle patterns and a long output hold-off",
                 n_beats);
        if (n_err == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
